[sv/tlp_pkg.sv]
// Shared types, character codes and label tables of the meter line parser.
package tlp_pkg;

    localparam int unsigned VALUE_BITS_DEFAULT = 32;
    localparam int unsigned OUT_BITS = 32;

    localparam logic [7:0] LINE_FEED  = 8'h0A;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [31:0] ENERGY_LABEL = "BASE";
    localparam logic [31:0] POWER_LABEL  = "PAPP";
    localparam logic [2:0]  LABEL_LEN    = 3'd4;
    localparam logic [2:0]  LABEL_POS_MAX = 3'd5;

    // Accumulator control from the line sequencer.
    typedef struct packed {
        logic clear;
        logic feed;
    } t_acc_ctrl;

    // One result item.
    typedef struct packed {
        logic [OUT_BITS-1:0] energy_wh;
        logic [OUT_BITS-1:0] apparent_power_va;
        logic                energy_updated;
        logic                power_updated;
        logic                data_available;
    } t_result;

    // Character idx (0 = first) of a four-character label.
    function automatic logic [7:0] label_char(input logic [31:0] label,
                                              input logic [1:0]  idx);
        logic [7:0] ch;
        unique case (idx)
            2'd0:    ch = label[31:24];
            2'd1:    ch = label[23:16];
            2'd2:    ch = label[15:8];
            default: ch = label[7:0];
        endcase
        return ch;
    endfunction

endpackage

[sv/tlp_if.sv]
// Handshake channels of the meter line parser: received bytes and results.
interface tlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlp_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] energy_wh;
    logic [31:0] apparent_power_va;
    logic        energy_updated;
    logic        power_updated;
    logic        data_available;

    modport source (output valid, output energy_wh, output apparent_power_va,
                    output energy_updated, output power_updated,
                    output data_available, input ready);
    modport sink   (input valid, input energy_wh, input apparent_power_va,
                    input energy_updated, input power_updated,
                    input data_available, output ready);
endinterface

[sv/meter_teleinfo_line_parser_unit.sv]
// Top level of the meter information line parser.
//
// Usage:
//   i_rx_byte takes one received character per item (valid/ready). Bytes
//   before the first line feed are ignored; after it a label is gathered
//   up to a space, and "BASE" or "PAPP" selects a decimal value that runs
//   to the next space. A line feed always restarts the label and drops a
//   value still being read.
//   o_result gives one item per input byte: both stored values (low 32
//   bits), the two update strobes and the data-available flag.
// Timing:
//   Every byte is handled in the cycle it is accepted; its result item is
//   registered in the result register, or in the skid entry while a result
//   waits. One byte per cycle is sustained while the skid entry is empty;
//   the per-byte path is one compare tree plus the x10 add of the accumulator.
// Stall:
//   A two-entry output stage (result register plus skid) keeps
//   i_rx_byte.ready high while one result waits; ready drops only when
//   both entries are full.
// Reset:
//   Synchronous, active low. Parser waits for a line feed, stored values
//   and flags are zero, the output stage is empty.
module meter_teleinfo_line_parser_unit #(
    parameter int unsigned VALUE_BITS = tlp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tlp_byte_if.sink      i_rx_byte,
    tlp_result_if.source  o_result
);

    localparam int unsigned OUT_BITS = tlp_pkg::OUT_BITS;

    typedef enum logic [1:0] {
        MODE_WAIT,
        MODE_LABEL,
        MODE_VALUE
    } t_mode;

    // Parser state
    t_mode                 r_mode, n_mode;
    logic [2:0]            r_label_pos, n_label_pos;
    logic [1:0]            r_match, n_match;       // bit0 BASE, bit1 PAPP
    logic                  r_is_power, n_is_power;
    logic [VALUE_BITS-1:0] r_energy, n_energy;
    logic [VALUE_BITS-1:0] r_power, n_power;
    logic [1:0]            r_parsed, n_parsed;

    // Output stage
    logic                  r_out_valid;
    tlp_pkg::t_result      r_out;
    logic                  r_skid_valid;
    tlp_pkg::t_result      r_skid;

    logic                  in_fire;
    logic                  out_fire;
    logic [7:0]            ch;
    logic                  e_upd;
    logic                  p_upd;
    logic [VALUE_BITS-1:0] acc_value;
    tlp_pkg::t_acc_ctrl    acc_ctrl;
    tlp_pkg::t_result      new_res;

    assign ch        = i_rx_byte.rx_byte;
    assign in_fire   = i_rx_byte.valid && i_rx_byte.ready;
    assign out_fire  = r_out_valid && o_result.ready;
    assign i_rx_byte.ready = !r_skid_valid;

    tlp_value_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_value_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (acc_ctrl),
        .i_char  (ch),
        .o_value (acc_value)
    );

    // Next parser state for the byte at the input
    always_comb begin
        n_mode        = r_mode;
        n_label_pos   = r_label_pos;
        n_match       = r_match;
        n_is_power    = r_is_power;
        n_energy      = r_energy;
        n_power       = r_power;
        n_parsed      = r_parsed;
        e_upd         = 1'b0;
        p_upd         = 1'b0;
        acc_ctrl      = '0;

        if (ch == tlp_pkg::LINE_FEED) begin
            n_mode         = MODE_LABEL;
            n_label_pos    = '0;
            n_match        = 2'b11;
            n_is_power     = 1'b0;
            acc_ctrl.clear = 1'b1;
        end else begin
            unique case (r_mode)
                MODE_LABEL: begin
                    if (ch == tlp_pkg::SPACE_CHAR) begin
                        acc_ctrl.clear = 1'b1;
                        if (r_label_pos == tlp_pkg::LABEL_LEN && r_match[0]) begin
                            n_is_power = 1'b0;
                            n_mode     = MODE_VALUE;
                        end else if (r_label_pos == tlp_pkg::LABEL_LEN && r_match[1]) begin
                            n_is_power = 1'b1;
                            n_mode     = MODE_VALUE;
                        end else begin
                            n_mode = MODE_WAIT;
                        end
                    end else begin
                        if (r_label_pos < tlp_pkg::LABEL_LEN) begin
                            if (ch != tlp_pkg::label_char(tlp_pkg::ENERGY_LABEL,
                                                          r_label_pos[1:0])) begin
                                n_match[0] = 1'b0;
                            end
                            if (ch != tlp_pkg::label_char(tlp_pkg::POWER_LABEL,
                                                          r_label_pos[1:0])) begin
                                n_match[1] = 1'b0;
                            end
                        end
                        if (r_label_pos < tlp_pkg::LABEL_POS_MAX) begin
                            n_label_pos = r_label_pos + 3'd1;
                        end
                    end
                end
                MODE_VALUE: begin
                    if (ch == tlp_pkg::SPACE_CHAR) begin
                        if (r_is_power) begin
                            n_power     = acc_value;
                            n_parsed[1] = 1'b1;
                            p_upd       = 1'b1;
                        end else begin
                            n_energy    = acc_value;
                            n_parsed[0] = 1'b1;
                            e_upd       = 1'b1;
                        end
                        n_is_power = 1'b0;
                        n_mode     = MODE_WAIT;
                    end else begin
                        acc_ctrl.feed = 1'b1;
                    end
                end
                default: begin
                    n_mode = MODE_WAIT;
                end
            endcase
        end

        // Gate accumulator strobes with the handshake
        acc_ctrl.clear = acc_ctrl.clear && in_fire;
        acc_ctrl.feed  = acc_ctrl.feed && in_fire;
    end

    // Values narrower than the outputs are zero-extended, wider ones cut
    always_comb begin
        new_res.energy_wh         = OUT_BITS'(n_energy);
        new_res.apparent_power_va = OUT_BITS'(n_power);
        new_res.energy_updated    = e_upd;
        new_res.power_updated     = p_upd;
        new_res.data_available    = &n_parsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_WAIT;
            r_label_pos <= '0;
            r_match     <= 2'b11;
            r_is_power  <= 1'b0;
            r_energy    <= '0;
            r_power     <= '0;
            r_parsed    <= '0;
        end else if (in_fire) begin
            r_mode      <= n_mode;
            r_label_pos <= n_label_pos;
            r_match     <= n_match;
            r_is_power  <= n_is_power;
            r_energy    <= n_energy;
            r_power     <= n_power;
            r_parsed    <= n_parsed;
        end
    end

    // Result register with one skid entry behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (in_fire) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= new_res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= new_res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.energy_wh         = r_out.energy_wh;
    assign o_result.apparent_power_va = r_out.apparent_power_va;
    assign o_result.energy_updated    = r_out.energy_updated;
    assign o_result.power_updated     = r_out.power_updated;
    assign o_result.data_available    = r_out.data_available;

    // The skid entry is only ever filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty result register");

    // A value is read only after a full four-character label
    a_value_after_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_VALUE) |-> (r_label_pos == tlp_pkg::LABEL_LEN))
        else $error("value mode entered without a four-character label");

    // Parsed flags never clear outside reset (checked here for the energy flag)
    a_parsed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_parsed[0] |=> r_parsed[0])
        else $error("energy parsed flag dropped");

    // One byte completes at most one value
    a_single_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.energy_updated && r_out.power_updated))
        else $error("both update strobes set in one result");

endmodule

[sv/tlp_value_acc.sv]
// Decimal value accumulator with saturation and end-of-digits tracking.
module tlp_value_acc #(
    parameter int unsigned VALUE_BITS = tlp_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tlp_pkg::t_acc_ctrl    i_ctrl,
    input  logic [7:0]            i_char,
    output logic [VALUE_BITS-1:0] o_value
);

    localparam int unsigned WIDE_BITS = VALUE_BITS + 4;

    logic [VALUE_BITS-1:0] r_acc;
    logic                  r_digits_ended;
    logic [VALUE_BITS-1:0] n_acc;
    logic [WIDE_BITS-1:0]  acc_x10d;
    logic                  is_digit;

    assign is_digit = (i_char >= tlp_pkg::CHAR_ZERO) && (i_char <= tlp_pkg::CHAR_NINE);

    // acc*10 + digit as shift-and-add; anything above VALUE_BITS saturates
    assign acc_x10d = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                    + {{(WIDE_BITS-4){1'b0}}, i_char[3:0]};

    always_comb begin
        if (acc_x10d[WIDE_BITS-1:VALUE_BITS] != 4'd0) begin
            n_acc = {VALUE_BITS{1'b1}};
        end else begin
            n_acc = acc_x10d[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc          <= '0;
            r_digits_ended <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_acc          <= '0;
            r_digits_ended <= 1'b0;
        end else if (i_ctrl.feed && !r_digits_ended) begin
            if (is_digit) begin
                r_acc <= n_acc;
            end else begin
                r_digits_ended <= 1'b1;
            end
        end
    end

    assign o_value = r_acc;

endmodule
